/* src/cau_pkg.sv */
// shared constants, types and helpers for the complex arithmetic unit
// used by cau_step and complex_arithmetic_unit; no dependencies
package cau_pkg;

    localparam int FRAC_BITS = 16;
    // quotient bits kept per divide part: quotient below 2^34, with one extra fraction bit
    localparam int QBITS     = 34;
    localparam int DIV_SH    = QBITS - 1 - FRAC_BITS;
    localparam int SQ_STEPS  = 32;
    localparam int N_STEPS   = QBITS;
    localparam int SQ_REM_W  = 34;

    localparam logic [64:0] RND_HALF = 65'((65'd1 << FRAC_BITS) >> 1);

    localparam logic [2:0] OP_ADD  = 3'd0;
    localparam logic [2:0] OP_SUB  = 3'd1;
    localparam logic [2:0] OP_MUL  = 3'd2;
    localparam logic [2:0] OP_DIV  = 3'd3;
    localparam logic [2:0] OP_MAG  = 3'd4;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_SAT  = 2'd1;
    localparam logic [1:0] ST_DZ   = 2'd2;

    typedef struct packed {
        logic       sat;
        logic [31:0] val;
    } t_clamp;

    // sideband that travels beside the iterative work
    typedef struct packed {
        logic [2:0]  op;
        logic        dzero;
        logic        re_neg;
        logic        im_neg;
        logic        re_ovf;
        logic        im_ovf;
        logic [31:0] early_re;
        logic [31:0] early_im;
        logic [1:0]  early_st;
    } t_side;

    typedef struct packed {
        logic [63:0]          den;
        logic [63:0]          re_rem;
        logic [63:0]          im_rem;
        logic [QBITS-1:0]     re_q;
        logic [QBITS-1:0]     im_q;
        logic [QBITS-1:0]     re_low;
        logic [QBITS-1:0]     im_low;
        logic [63:0]          sq_src;
        logic [SQ_REM_W-1:0]  sq_rem;
        logic [31:0]          sq_root;
    } t_work;

    // clamp a sign and magnitude into 32 signed bits
    function automatic t_clamp clamp_mag(input logic neg, input logic [64:0] q);
        t_clamp c;
        c.sat = 1'b0;
        if (!neg) begin
            if (q > 65'h7FFF_FFFF) begin
                c.sat = 1'b1;
                c.val = 32'h7FFF_FFFF;
            end else begin
                c.val = q[31:0];
            end
        end else begin
            c.sat = (q > 65'h8000_0000);
            if (q >= 65'h8000_0000) begin
                c.val = 32'h8000_0000;
            end else begin
                c.val = 32'(-q[31:0]);
            end
        end
        return c;
    endfunction

endpackage

/* src/complex_arithmetic_unit.sv */
// top level of the complex arithmetic unit: front stages, iterative step chain, output
// depends on cau_pkg and cau_step
//
// Fully pipelined: a request is taken on any cycle that start is high (busy is always
// low), one per clock. Each request gives one result, marked by o_done for one cycle,
// once it has passed four front stages (products, sums, magnitudes, setup), one stage
// per quotient bit of the divider chain (34), and the output register. Results come out
// in request order for every op; the receiver cannot stall them. Divide rounds to
// nearest, ties away from zero; a zero divisor gives zero parts with status 2; a part
// that does not fit saturates with status 1.
module complex_arithmetic_unit import cau_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [2:0]         i_op,
    input  logic signed [31:0] i_a_re,
    input  logic signed [31:0] i_a_im,
    input  logic signed [31:0] i_b_re,
    input  logic signed [31:0] i_b_im,
    output logic               o_done,
    output logic signed [31:0] o_res_re,
    output logic signed [31:0] o_res_im,
    output logic [1:0]         o_status
);

    // stage a: products and plain sums
    logic               r_a_valid;
    logic [2:0]         r_a_op;
    logic signed [63:0] r_a_prr, r_a_pii, r_a_pir, r_a_pri, r_a_sq1, r_a_sq2;
    logic signed [32:0] r_a_sr, r_a_si;
    logic signed [31:0] sq_x, sq_y;
    logic signed [32:0] n_a_sr, n_a_si;

    // stage b: product sums and divisor
    logic               r_b_valid;
    logic [2:0]         r_b_op;
    logic signed [64:0] r_b_nre, r_b_nim;
    logic [63:0]        r_b_den;
    logic [31:0]        r_b_ere, r_b_eim;
    logic [1:0]         r_b_est;
    logic signed [64:0] n_b_nre, n_b_nim;
    logic [31:0]        n_b_ere, n_b_eim;
    logic [1:0]         n_b_est;

    // stage c: sign and magnitude
    logic               r_c_valid;
    logic [2:0]         r_c_op;
    logic               r_c_re_neg, r_c_im_neg, r_c_dz;
    logic [63:0]        r_c_re_mag, r_c_im_mag, r_c_den;
    logic [31:0]        r_c_ere, r_c_eim;
    logic [1:0]         r_c_est;

    // setup into the step chain
    logic               r_d_valid;
    t_side              r_d_side;
    t_work              r_d_work;
    t_side              n_d_side;
    t_work              n_d_work;
    t_clamp             mul_re, mul_im;
    logic [63:0]        re_top, im_top;

    logic               w_valid [0:N_STEPS];
    t_side              w_side  [0:N_STEPS];
    t_work              w_work  [0:N_STEPS];

    // output
    logic               r_done;
    logic [31:0]        r_res_re, r_res_im;
    logic [1:0]         r_status;
    logic [31:0]        n_res_re, n_res_im;
    logic [1:0]         n_status;
    t_side              f_side;
    t_work              f_work;
    logic [QBITS:0]     re_rnd, im_rnd;
    logic [32:0]        sq_rnd;
    t_clamp             div_re, div_im, mag_c;

    assign busy = 1'b0;

    // ---------------- stage a
    always_comb begin
        sq_x = (i_op == OP_MAG) ? i_a_re : i_b_re;
        sq_y = (i_op == OP_MAG) ? i_a_im : i_b_im;
        if (i_op == OP_SUB) begin
            n_a_sr = {i_a_re[31], i_a_re} - {i_b_re[31], i_b_re};
            n_a_si = {i_a_im[31], i_a_im} - {i_b_im[31], i_b_im};
        end else begin
            n_a_sr = {i_a_re[31], i_a_re} + {i_b_re[31], i_b_re};
            n_a_si = {i_a_im[31], i_a_im} + {i_b_im[31], i_b_im};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
            r_c_valid <= 1'b0;
            r_d_valid <= 1'b0;
            r_done    <= 1'b0;
        end else begin
            r_a_valid <= start & ~busy;
            r_b_valid <= r_a_valid;
            r_c_valid <= r_b_valid;
            r_d_valid <= r_c_valid;
            r_done    <= w_valid[N_STEPS];
        end
    end

    always_ff @(posedge i_clk) begin
        r_a_op  <= i_op;
        r_a_prr <= i_a_re * i_b_re;
        r_a_pii <= i_a_im * i_b_im;
        r_a_pir <= i_a_im * i_b_re;
        r_a_pri <= i_a_re * i_b_im;
        r_a_sq1 <= sq_x * sq_x;
        r_a_sq2 <= sq_y * sq_y;
        r_a_sr  <= n_a_sr;
        r_a_si  <= n_a_si;
    end

    // ---------------- stage b
    always_comb begin
        if (r_a_op == OP_MUL) begin
            n_b_nre = {r_a_prr[63], r_a_prr} - {r_a_pii[63], r_a_pii};
            n_b_nim = {r_a_pir[63], r_a_pir} + {r_a_pri[63], r_a_pri};
        end else begin
            n_b_nre = {r_a_prr[63], r_a_prr} + {r_a_pii[63], r_a_pii};
            n_b_nim = {r_a_pir[63], r_a_pir} - {r_a_pri[63], r_a_pri};
        end
        n_b_ere = '0;
        n_b_eim = '0;
        n_b_est = ST_OK;
        if (r_a_op == OP_ADD || r_a_op == OP_SUB) begin
            n_b_ere = r_a_sr[31:0];
            n_b_eim = r_a_si[31:0];
            if (r_a_sr[32] != r_a_sr[31]) begin
                n_b_ere = r_a_sr[32] ? 32'h8000_0000 : 32'h7FFF_FFFF;
                n_b_est = ST_SAT;
            end
            if (r_a_si[32] != r_a_si[31]) begin
                n_b_eim = r_a_si[32] ? 32'h8000_0000 : 32'h7FFF_FFFF;
                n_b_est = ST_SAT;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_b_op  <= r_a_op;
        r_b_nre <= n_b_nre;
        r_b_nim <= n_b_nim;
        r_b_den <= $unsigned(r_a_sq1) + $unsigned(r_a_sq2);
        r_b_ere <= n_b_ere;
        r_b_eim <= n_b_eim;
        r_b_est <= n_b_est;
    end

    // ---------------- stage c
    always_ff @(posedge i_clk) begin
        r_c_op     <= r_b_op;
        r_c_re_neg <= r_b_nre[64];
        r_c_im_neg <= r_b_nim[64];
        r_c_re_mag <= r_b_nre[64] ? 64'(-r_b_nre) : r_b_nre[63:0];
        r_c_im_mag <= r_b_nim[64] ? 64'(-r_b_nim) : r_b_nim[63:0];
        r_c_den    <= r_b_den;
        r_c_dz     <= (r_b_den == '0);
        r_c_ere    <= r_b_ere;
        r_c_eim    <= r_b_eim;
        r_c_est    <= r_b_est;
    end

    // ---------------- stage d: multiply rescale and chain setup
    always_comb begin
        mul_re = clamp_mag(r_c_re_neg, 65'(({1'b0, r_c_re_mag} + RND_HALF) >> FRAC_BITS));
        mul_im = clamp_mag(r_c_im_neg, 65'(({1'b0, r_c_im_mag} + RND_HALF) >> FRAC_BITS));
        re_top = r_c_re_mag >> DIV_SH;
        im_top = r_c_im_mag >> DIV_SH;

        n_d_side.op       = r_c_op;
        n_d_side.dzero    = r_c_dz;
        n_d_side.re_neg   = r_c_re_neg;
        n_d_side.im_neg   = r_c_im_neg;
        // quotient would reach 2^QBITS: saturates whatever the low bits are
        n_d_side.re_ovf   = (re_top >= r_c_den);
        n_d_side.im_ovf   = (im_top >= r_c_den);
        n_d_side.early_re = r_c_ere;
        n_d_side.early_im = r_c_eim;
        n_d_side.early_st = r_c_est;
        if (r_c_op == OP_MUL) begin
            n_d_side.early_re = mul_re.val;
            n_d_side.early_im = mul_im.val;
            n_d_side.early_st = (mul_re.sat | mul_im.sat) ? ST_SAT : ST_OK;
        end

        n_d_work.den     = r_c_den;
        n_d_work.re_rem  = re_top;
        n_d_work.im_rem  = im_top;
        n_d_work.re_q    = '0;
        n_d_work.im_q    = '0;
        n_d_work.re_low  = QBITS'(r_c_re_mag << (FRAC_BITS + 1));
        n_d_work.im_low  = QBITS'(r_c_im_mag << (FRAC_BITS + 1));
        n_d_work.sq_src  = r_c_den;
        n_d_work.sq_rem  = '0;
        n_d_work.sq_root = '0;
    end

    always_ff @(posedge i_clk) begin
        r_d_side <= n_d_side;
        r_d_work <= n_d_work;
    end

    // ---------------- step chain
    assign w_valid[0] = r_d_valid;
    assign w_side[0]  = r_d_side;
    assign w_work[0]  = r_d_work;

    for (genvar k = 0; k < N_STEPS; k++) begin : g_step
        cau_step u_step (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_sq_en (1'(k < SQ_STEPS)),
            .i_valid (w_valid[k]),
            .i_side  (w_side[k]),
            .i_work  (w_work[k]),
            .o_valid (w_valid[k+1]),
            .o_side  (w_side[k+1]),
            .o_work  (w_work[k+1])
        );
    end

    // ---------------- rounding and result select
    always_comb begin
        f_side = w_side[N_STEPS];
        f_work = w_work[N_STEPS];
        // quotient carries one extra fraction bit: add one and drop it
        re_rnd = ({1'b0, f_work.re_q} + (QBITS+1)'(1)) >> 1;
        im_rnd = ({1'b0, f_work.im_q} + (QBITS+1)'(1)) >> 1;
        div_re = clamp_mag(f_side.re_neg,
                           f_side.re_ovf ? 65'h1_0000_0000 : 65'(re_rnd));
        div_im = clamp_mag(f_side.im_neg,
                           f_side.im_ovf ? 65'h1_0000_0000 : 65'(im_rnd));
        sq_rnd = {1'b0, f_work.sq_root}
               + 33'(f_work.sq_rem > SQ_REM_W'(f_work.sq_root));
        mag_c  = clamp_mag(1'b0, 65'(sq_rnd));

        case (f_side.op)
            OP_DIV: begin
                if (f_side.dzero) begin
                    n_res_re = '0;
                    n_res_im = '0;
                    n_status = ST_DZ;
                end else begin
                    n_res_re = div_re.val;
                    n_res_im = div_im.val;
                    n_status = (div_re.sat | div_im.sat) ? ST_SAT : ST_OK;
                end
            end
            OP_MAG: begin
                n_res_re = mag_c.val;
                n_res_im = '0;
                n_status = mag_c.sat ? ST_SAT : ST_OK;
            end
            default: begin
                n_res_re = f_side.early_re;
                n_res_im = f_side.early_im;
                n_status = f_side.early_st;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_res_re <= n_res_re;
        r_res_im <= n_res_im;
        r_status <= n_status;
    end

    assign o_done   = r_done;
    assign o_res_re = r_res_re;
    assign o_res_im = r_res_im;
    assign o_status = r_status;

endmodule

/* src/cau_step.sv */
// one pipeline stage of the iterative datapath: a restoring divide step on
// both parts and, when enabled, one square-root digit; uses cau_pkg
module cau_step import cau_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_sq_en,
    input  logic  i_valid,
    input  t_side i_side,
    input  t_work i_work,
    output logic  o_valid,
    output t_side o_side,
    output t_work o_work
);

    logic  r_valid;
    t_side r_side;
    t_work r_work;
    t_work n_work;

    logic [64:0]         re_try, im_try;
    logic                re_ge, im_ge;
    logic [SQ_REM_W+1:0] sq_try;
    logic [SQ_REM_W+1:0] sq_t;
    logic                sq_ge;

    always_comb begin
        n_work = i_work;

        re_try = {i_work.re_rem, i_work.re_low[QBITS-1]};
        im_try = {i_work.im_rem, i_work.im_low[QBITS-1]};
        re_ge  = (re_try >= {1'b0, i_work.den});
        im_ge  = (im_try >= {1'b0, i_work.den});
        n_work.re_rem = re_ge ? 64'(re_try - {1'b0, i_work.den}) : re_try[63:0];
        n_work.im_rem = im_ge ? 64'(im_try - {1'b0, i_work.den}) : im_try[63:0];
        n_work.re_q   = {i_work.re_q[QBITS-2:0], re_ge};
        n_work.im_q   = {i_work.im_q[QBITS-2:0], im_ge};
        n_work.re_low = {i_work.re_low[QBITS-2:0], 1'b0};
        n_work.im_low = {i_work.im_low[QBITS-2:0], 1'b0};

        // digit-by-digit root: bring down two bits, try (root << 2) | 1
        sq_try = {i_work.sq_rem, i_work.sq_src[63:62]};
        sq_t   = (SQ_REM_W+2)'({i_work.sq_root, 2'b01});
        sq_ge  = (sq_try >= sq_t);
        if (i_sq_en) begin
            n_work.sq_src  = {i_work.sq_src[61:0], 2'b00};
            n_work.sq_rem  = sq_ge ? SQ_REM_W'(sq_try - sq_t) : SQ_REM_W'(sq_try);
            n_work.sq_root = {i_work.sq_root[30:0], sq_ge};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_side <= i_side;
        r_work <= n_work;
    end

    assign o_valid = r_valid;
    assign o_side  = r_side;
    assign o_work  = r_work;

endmodule

/* tb/cau_checker.sv */
// checker for the complex arithmetic unit: watches requests and results, predicts and compares
// depends on cau_pkg for op and status codes
module cau_checker import cau_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    input  logic               busy,
    input  logic [2:0]         i_op,
    input  logic signed [31:0] i_a_re,
    input  logic signed [31:0] i_a_im,
    input  logic signed [31:0] i_b_re,
    input  logic signed [31:0] i_b_im,
    input  logic               o_done,
    input  logic signed [31:0] o_res_re,
    input  logic signed [31:0] o_res_im,
    input  logic [1:0]         o_status,
    output int                 fail_count,
    output int                 pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic [31:0] re;
        logic [31:0] im;
        logic [1:0]  status;
    } t_cplx_result;

    t_cplx_result expected_results[$];

    function automatic logic [31:0] clamp_part(input logic neg, input logic [127:0] q,
                                               inout logic sat);
        if (!neg) begin
            if (q > 128'h7FFF_FFFF) begin
                sat = 1'b1;
                return 32'h7FFF_FFFF;
            end
            return q[31:0];
        end
        if (q > 128'h8000_0000) sat = 1'b1;
        if (q >= 128'h8000_0000) return 32'h8000_0000;
        return 32'(-q[31:0]);
    endfunction

    function automatic logic [63:0] sqrt_rounded(input logic [63:0] n);
        logic [63:0] root;
        logic [63:0] one_bit;
        root = '0;
        one_bit = 64'd1 << 62;
        while (one_bit > n) one_bit >>= 2;
        while (one_bit != 0) begin
            if (n >= root + one_bit) begin
                n = n - (root + one_bit);
                root = (root >> 1) + one_bit;
            end else begin
                root >>= 1;
            end
            one_bit >>= 2;
        end
        if (n > root) root++;
        return root;
    endfunction

    // rounded quotient with FRAC_BITS fraction bits, ties away from zero
    function automatic logic [31:0] divide_rounded(input logic signed [65:0] num,
                                                   input logic [63:0] den, inout logic sat);
        logic [127:0] mag;
        logic [127:0] q;
        logic [127:0] r;
        mag = num[65] ? 128'(-num) : 128'(num);
        mag = mag << FRAC_BITS;
        q = mag / den;
        r = mag % den;
        if ((r << 1) >= den) q++;
        return clamp_part(num[65], q, sat);
    endfunction

    function automatic logic [31:0] rescale_sum(input logic signed [65:0] v, inout logic sat);
        logic [127:0] mag;
        mag = v[65] ? 128'(-v) : 128'(v);
        mag = (mag + ((128'd1 << FRAC_BITS) >> 1)) >> FRAC_BITS;
        return clamp_part(v[65], mag, sat);
    endfunction

    function automatic t_cplx_result predict_result(input logic [2:0] op,
            input logic signed [31:0] ar, input logic signed [31:0] ai,
            input logic signed [31:0] br, input logic signed [31:0] bi);
        t_cplx_result r;
        logic sat;
        longint sr, si;
        logic signed [65:0] nr, ni;
        logic [63:0] den;
        r.re = '0;
        r.im = '0;
        r.status = ST_OK;
        sat = 1'b0;
        case (op)
            OP_ADD, OP_SUB: begin
                sr = (op == OP_ADD) ? longint'(ar) + longint'(br) : longint'(ar) - longint'(br);
                si = (op == OP_ADD) ? longint'(ai) + longint'(bi) : longint'(ai) - longint'(bi);
                r.re = clamp_part(sr < 0, sr < 0 ? 128'(-sr) : 128'(sr), sat);
                r.im = clamp_part(si < 0, si < 0 ? 128'(-si) : 128'(si), sat);
            end
            OP_MUL: begin
                nr = 66'(longint'(ar) * longint'(br)) - 66'(longint'(ai) * longint'(bi));
                ni = 66'(longint'(ai) * longint'(br)) + 66'(longint'(ar) * longint'(bi));
                r.re = rescale_sum(nr, sat);
                r.im = rescale_sum(ni, sat);
            end
            OP_DIV: begin
                den = 64'(longint'(br) * longint'(br)) + 64'(longint'(bi) * longint'(bi));
                if (den == 0) begin
                    r.status = ST_DZ;
                end else begin
                    nr = 66'(longint'(ar) * longint'(br)) + 66'(longint'(ai) * longint'(bi));
                    ni = 66'(longint'(ai) * longint'(br)) - 66'(longint'(ar) * longint'(bi));
                    r.re = divide_rounded(nr, den, sat);
                    r.im = divide_rounded(ni, den, sat);
                end
            end
            OP_MAG: begin
                den = 64'(longint'(ar) * longint'(ar)) + 64'(longint'(ai) * longint'(ai));
                r.re = clamp_part(1'b0, 128'(sqrt_rounded(den)), sat);
            end
            default: ;
        endcase
        if (r.status == ST_OK && sat) r.status = ST_SAT;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("%0t: mismatch on %s: got %h, expected %h", $realtime, what, got, want);
        fail_count++;
    endtask

    always @(posedge i_clk) begin
        t_cplx_result want;
        if (i_rst_n) begin
            if (start && !busy) begin
                expected_results.push_back(predict_result(i_op, i_a_re, i_a_im, i_b_re, i_b_im));
            end
            if (o_done) begin
                if (expected_results.size() == 0) begin
                    report_mismatch("unexpected result", o_res_re, '0);
                end else begin
                    want = expected_results.pop_front();
                    if (o_res_re !== want.re) report_mismatch("res_re", o_res_re, want.re);
                    if (o_res_im !== want.im) report_mismatch("res_im", o_res_im, want.im);
                    if (o_status !== want.status)
                        report_mismatch("status", 32'(o_status), 32'(want.status));
                end
            end
            pending = expected_results.size();
        end
    end

endmodule

/* tb/tb.sv */
// top of the complex arithmetic unit testbench: clock, reset, request stimulus, verdict
// depends on cau_pkg, complex_arithmetic_unit and cau_checker
module tb import cau_pkg::*; ;
    timeunit 1ns;
    timeprecision 1ps;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               start = 1'b0;
    logic               busy;
    logic [2:0]         i_op = OP_ADD;
    logic signed [31:0] i_a_re = '0;
    logic signed [31:0] i_a_im = '0;
    logic signed [31:0] i_b_re = '0;
    logic signed [31:0] i_b_im = '0;
    logic               o_done;
    logic signed [31:0] o_res_re;
    logic signed [31:0] o_res_im;
    logic [1:0]         o_status;
    int                 fail_count;
    int                 pending;

    localparam logic signed [31:0] MAXV = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] MINV = 32'sh8000_0000;
    localparam logic signed [31:0] ONE  = 32'sh0001_0000;
    localparam int LATENCY = 39;

    always #5 i_clk = ~i_clk;

    complex_arithmetic_unit DUT (.*);

    cau_checker checker_i (.*);

    task automatic send_request(input logic [2:0] op, input logic signed [31:0] ar,
            input logic signed [31:0] ai, input logic signed [31:0] br,
            input logic signed [31:0] bi);
        @(negedge i_clk);
        start <= 1'b1;
        i_op <= op;
        i_a_re <= ar;
        i_a_im <= ai;
        i_b_re <= br;
        i_b_im <= bi;
        do @(posedge i_clk); while (busy);
    endtask

    task automatic idle_cycles(input int n);
        @(negedge i_clk);
        start <= 1'b0;
        repeat (n - 1) @(negedge i_clk);
    endtask

    function automatic logic signed [31:0] pick_operand();
        case ($urandom_range(0, 9))
            0: return MAXV;
            1: return MINV;
            2: return ($urandom_range(0, 1)) ? ONE : -ONE;
            3: return 32'sd0;
            4, 5, 6: return 32'($urandom_range(0, 32'h000F_FFFF)) - 32'sh0008_0000;
            default: return 32'($urandom);
        endcase
    endfunction

    initial begin
        logic [2:0] op;
        int burst;
        int sent;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // extremes, ties, zero divisor and the unused codes
        send_request(OP_ADD, MAXV, MINV, MAXV, MINV);
        send_request(OP_ADD, 32'sd5, -32'sd7, 32'sd9, 32'sd3);
        send_request(OP_SUB, MINV, MAXV, MAXV, MINV);
        send_request(OP_SUB, MINV, 32'sd0, 32'sd0, -32'sd1);
        send_request(OP_MUL, MAXV, MAXV, MAXV, MAXV);
        send_request(OP_MUL, MINV, MINV, MINV, MINV);
        send_request(OP_MUL, 32'sd1, 32'sd0, 32'sh0000_8000, 32'sd0);
        send_request(OP_MUL, -32'sd1, 32'sd0, 32'sh0000_8000, 32'sd0);
        send_request(OP_MUL, 2 * ONE, ONE, 3 * ONE, -ONE);
        send_request(OP_DIV, ONE, ONE, 32'sd0, 32'sd0);
        send_request(OP_DIV, MINV, MAXV, 32'sd1, 32'sd0);
        send_request(OP_DIV, 6 * ONE, 8 * ONE, 3 * ONE, 4 * ONE);
        send_request(OP_DIV, ONE, 32'sd0, 3 * ONE, 32'sd0);
        send_request(OP_DIV, MINV, MINV, MINV, MINV);
        send_request(OP_DIV, -ONE, 32'sd0, MAXV, MAXV);
        send_request(OP_MAG, 3 * ONE, 4 * ONE, 32'sd0, 32'sd0);
        send_request(OP_MAG, MINV, MINV, MAXV, MAXV);
        send_request(OP_MAG, MAXV, 32'sd0, 32'sd0, 32'sd0);
        send_request(OP_MAG, 32'sd0, 32'sd0, 32'sd0, 32'sd0);
        send_request(3'd5, MAXV, MAXV, MAXV, MAXV);
        send_request(3'd6, MINV, MINV, MINV, MINV);
        send_request(3'd7, ONE, ONE, ONE, ONE);
        idle_cycles(3);

        sent = 0;
        while (sent < 2000) begin
            burst = $urandom_range(1, 30);
            repeat (burst) begin
                op = ($urandom_range(0, 15) == 0) ? 3'($urandom_range(5, 7))
                                                  : 3'($urandom_range(0, 4));
                send_request(op, pick_operand(), pick_operand(), pick_operand(),
                             pick_operand());
                sent++;
            end
            // drain the pipeline once midway
            if (sent >= 1000 && sent < 1000 + burst) begin
                idle_cycles(1);
                while (pending != 0) @(negedge i_clk);
            end
            if ($urandom_range(0, 3) != 0) idle_cycles($urandom_range(1, 15));
        end
        idle_cycles(1);

        while (pending != 0) @(posedge i_clk);
        repeat (LATENCY + 5) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    initial begin
        #3ms;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule

/* sim.f */
src/cau_pkg.sv
src/cau_step.sv
src/complex_arithmetic_unit.sv
tb/cau_checker.sv
tb/tb.sv
